FILE: hdl/resource_map_next_fit_allocator_assert.svh
// Assertion macros shared by the checker of the next-fit resource map allocator.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef RESOURCE_MAP_NEXT_FIT_ALLOCATOR_ASSERT_SVH
`define RESOURCE_MAP_NEXT_FIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RMNF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RMNF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

FILE: hdl/rmnf_pkg.sv
// Shared types and constants of the next-fit resource map allocator.
// No dependencies; used by the controller, the datapath, the top level and the checker.
package rmnf_pkg;

	localparam int FIELD_W  = 16;
	localparam int STATUS_W = 3;

	localparam logic [FIELD_W-1:0] DEFAULT_REGION = 16'd1000;

	// Request commands.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] STS_NO_SPACE   = 3'd1;
	localparam logic [STATUS_W-1:0] STS_BAD_ADDR   = 3'd2;
	localparam logic [STATUS_W-1:0] STS_TOO_BIG    = 3'd3;
	localparam logic [STATUS_W-1:0] STS_TABLE_FULL = 3'd4;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_RDL,
		ST_RDR,
		ST_NB,
		ST_PLAN,
		ST_ROUTE,
		ST_SHIFT,
		ST_WA,
		ST_WB,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic init;
		logic cfg_wr;
		logic load_req;
		logic check;
		logic scan;
		logic rd_left;
		logic rd_right;
		logic nb_cap;
		logic plan;
		logic shift;
		logic wr_a;
		logic wr_b;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic alloc_zero;
		logic scan_hit;
		logic scan_miss;
		logic act;
		logic shift_any;
		logic shift_done;
		logic wb_en;
	} dp_stat_t;

endpackage

FILE: hdl/rmnf_ctrl.sv
// Controller state machine of the next-fit resource map allocator.
// Depends on rmnf_pkg for the state type and the command and status structs.
module rmnf_ctrl
	import rmnf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     cfg_valid,
	input  dp_stat_t stat,
	output logic     busy,
	output logic     done,
	output logic     cfg_ready,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	// State register; reset starts with the table initialization.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: state_d = ST_IDLE;
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CHECK;
				end else if (cfg_valid) begin
					state_d = ST_INIT;
				end
			end
			ST_CHECK: state_d = stat.alloc_zero ? ST_DONE : ST_SCAN;
			ST_SCAN: begin
				if (stat.scan_hit) begin
					state_d = ST_RDL;
				end else if (stat.scan_miss) begin
					state_d = ST_DONE;
				end
			end
			ST_RDL:  state_d = ST_RDR;
			ST_RDR:  state_d = ST_NB;
			ST_NB:   state_d = ST_PLAN;
			ST_PLAN: state_d = ST_ROUTE;
			ST_ROUTE: begin
				if (!stat.act) begin
					state_d = ST_DONE;
				end else if (stat.shift_any) begin
					state_d = ST_SHIFT;
				end else begin
					state_d = ST_WA;
				end
			end
			ST_SHIFT: state_d = stat.shift_done ? ST_WA : ST_SHIFT;
			ST_WA:    state_d = stat.wb_en ? ST_WB : ST_DONE;
			ST_WB:    state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_INIT;
		endcase
	end

	// Output logic: at most one datapath command per state.
	always_comb begin
		cmd       = '0;
		busy      = 1'b1;
		done      = 1'b0;
		cfg_ready = 1'b0;
		case (state_q)
			ST_INIT: cmd.init = 1'b1;
			ST_IDLE: begin
				busy         = 1'b0;
				cfg_ready    = !start;
				cmd.load_req = start;
				cmd.cfg_wr   = cfg_valid && !start;
			end
			ST_CHECK: cmd.check    = 1'b1;
			ST_SCAN:  cmd.scan     = 1'b1;
			ST_RDL:   cmd.rd_left  = 1'b1;
			ST_RDR:   cmd.rd_right = 1'b1;
			ST_NB:    cmd.nb_cap   = 1'b1;
			ST_PLAN:  cmd.plan     = 1'b1;
			ST_ROUTE: cmd          = '0;
			ST_SHIFT: cmd.shift    = 1'b1;
			ST_WA:    cmd.wr_a     = 1'b1;
			ST_WB:    cmd.wr_b     = 1'b1;
			ST_DONE:  done         = 1'b1;
			default:  cmd          = '0;
		endcase
	end

endmodule

FILE: hdl/rmnf_dpath.sv
// Datapath of the next-fit resource map allocator: segment table memory,
// scan and shift engines, plan logic and result registers.
// Depends on rmnf_pkg for constants and the command and status structs.
module rmnf_dpath
	import rmnf_pkg::*;
#(
	parameter int MAX_SEGMENTS = 64,
	parameter int ADDR_BITS    = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic [FIELD_W-1:0]  cfg_data,
	input  logic                command,
	input  logic [FIELD_W-1:0]  size,
	input  logic [FIELD_W-1:0]  address,
	output logic [STATUS_W-1:0] status,
	output logic [FIELD_W-1:0]  start_res
);

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int SW = CW + 1;
	localparam int WW = (ADDR_BITS > FIELD_W) ? ADDR_BITS : FIELD_W;

	typedef struct packed {
		logic                 used;
		logic [ADDR_BITS-1:0] len;
		logic [ADDR_BITS-1:0] base;
	} ent_t;

	// Segment table memory with registered read data.
	ent_t mem_q [MAX_SEGMENTS];
	ent_t rdata_q;
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	ent_t          mem_wd;
	logic [IW-1:0] mem_ra;

	// Configuration, request and table bookkeeping.
	logic [FIELD_W-1:0] region_q;
	logic               req_cmd_q;
	logic [FIELD_W-1:0] req_size_q;
	logic [FIELD_W-1:0] req_addr_q;
	logic [CW-1:0]      count_q;
	logic [IW-1:0]      rover_q;

	// Scan engine.
	logic [IW-1:0] scan_addr_q;
	logic [CW-1:0] scan_n_q;
	logic          scan_v_s1;
	logic [IW-1:0] scan_idx_s1;
	logic          scan_match;

	// Found segment and its neighbors.
	logic [IW-1:0] fi_q;
	ent_t          fe_q;
	ent_t          left_q;
	ent_t          right_q;

	// Registered plan.
	logic                pl_act_q;
	logic                pl_shift_q;
	logic                pl_wb_q;
	logic [IW-1:0]       pl_wa_addr_q;
	ent_t                pl_wa_data_q;
	logic [IW-1:0]       pl_wb_addr_q;
	ent_t                pl_wb_data_q;

	// Shift engine.
	logic          sh_up_q;
	logic          sh_d2_q;
	logic [SW-1:0] sh_src_q;
	logic [SW-1:0] sh_left_q;
	logic          sh_v_s1;
	logic [IW-1:0] sh_dst_s1;

	// Result registers.
	logic [STATUS_W-1:0] res_status_q;
	logic [FIELD_W-1:0]  res_start_q;

	// Plan terms.
	logic [WW-1:0]        size_w;
	logic [WW-1:0]        len_w;
	logic [ADDR_BITS-1:0] sz_a;
	logic                 size_zero;
	logic                 is_alloc;
	logic                 full;
	logic                 has_left;
	logic                 has_right;
	logic                 lf;
	logic                 rf;
	logic [SW-1:0]        cnt_s;
	logic [SW-1:0]        fi_s;
	logic [SW-1:0]        dn1_src;
	logic [SW-1:0]        dn2_src;
	logic [IW-1:0]        rov_inc;
	logic [IW-1:0]        rov_dec;

	logic [STATUS_W-1:0]  p_status;
	logic                 p_act;
	logic                 p_shift;
	logic                 p_up;
	logic                 p_d2;
	logic [SW-1:0]        p_src;
	logic [SW-1:0]        p_moves;
	logic [IW-1:0]        p_wa_addr;
	ent_t                 p_wa_data;
	logic                 p_wb;
	logic [IW-1:0]        p_wb_addr;
	ent_t                 p_wb_data;
	logic [CW-1:0]        p_count;
	logic [IW-1:0]        p_rover;

	assign size_w    = WW'(req_size_q);
	assign len_w     = WW'(fe_q.len);
	assign sz_a      = ADDR_BITS'(req_size_q);
	assign size_zero = (req_size_q == '0);
	assign is_alloc  = (req_cmd_q == CMD_ALLOC);
	assign full      = (count_q == CW'(MAX_SEGMENTS));
	assign cnt_s     = SW'(count_q);
	assign fi_s      = SW'(fi_q);
	assign has_left  = (fi_q != '0);
	assign has_right = ((fi_s + SW'(1)) < cnt_s);
	assign lf        = has_left && !left_q.used;
	assign rf        = has_right && !right_q.used;
	assign dn1_src   = fi_s + SW'(1);
	assign dn2_src   = fi_s + SW'(2);
	assign rov_inc   = (rover_q >= fi_q) ? (rover_q + IW'(1)) : rover_q;
	assign rov_dec   = (rover_q >= fi_q) ? (rover_q - IW'(1)) : rover_q;

	// Scan match: a free segment large enough, or a used segment at the address.
	always_comb begin
		if (is_alloc) begin
			scan_match = !rdata_q.used && (WW'(rdata_q.len) >= size_w);
		end else begin
			scan_match = rdata_q.used && (WW'(rdata_q.base) == WW'(req_addr_q));
		end
	end

	// Plan of the table update for the found segment.
	always_comb begin
		p_status  = STS_OK;
		p_act     = 1'b0;
		p_shift   = 1'b0;
		p_up      = 1'b0;
		p_d2      = 1'b0;
		p_src     = '0;
		p_moves   = '0;
		p_wa_addr = fi_q;
		p_wa_data = fe_q;
		p_wb      = 1'b0;
		p_wb_addr = fi_q + IW'(1);
		p_wb_data = fe_q;
		p_count   = count_q;
		p_rover   = rover_q;
		if (is_alloc) begin
			if (len_w == size_w) begin
				// Exact fit: mark used in place.
				p_act          = 1'b1;
				p_wa_data.used = 1'b1;
				p_rover        = fi_q;
			end else if (full) begin
				p_status = STS_TABLE_FULL;
			end else begin
				// Split: used front, free remainder behind it.
				p_act          = 1'b1;
				p_shift        = 1'b1;
				p_up           = 1'b1;
				p_src          = cnt_s - SW'(1);
				p_moves        = cnt_s - fi_s;
				p_wa_data.used = 1'b1;
				p_wa_data.len  = sz_a;
				p_wb           = 1'b1;
				p_wb_data.used = 1'b0;
				p_wb_data.len  = fe_q.len - sz_a;
				p_wb_data.base = fe_q.base + sz_a;
				p_count        = count_q + CW'(1);
				p_rover        = fi_q + IW'(1);
			end
		end else if (size_w > len_w) begin
			p_status = STS_TOO_BIG;
		end else if (size_zero) begin
			p_status = STS_OK;
		end else if (size_w == len_w) begin
			p_act = 1'b1;
			if (rf && lf) begin
				// Merge with both neighbors into the left one.
				p_wa_addr     = fi_q - IW'(1);
				p_wa_data     = left_q;
				p_wa_data.len = left_q.len + fe_q.len + right_q.len;
				p_shift       = (dn2_src < cnt_s);
				p_d2          = 1'b1;
				p_src         = dn2_src;
				p_moves       = (dn2_src < cnt_s) ? (cnt_s - dn2_src) : '0;
				p_count       = count_q - CW'(2);
				p_rover       = fi_q - IW'(1);
			end else if (rf) begin
				// Merge with the right neighbor.
				p_wa_data.used = 1'b0;
				p_wa_data.len  = fe_q.len + right_q.len;
				p_shift        = (dn2_src < cnt_s);
				p_src          = dn2_src;
				p_moves        = (dn2_src < cnt_s) ? (cnt_s - dn2_src) : '0;
				p_count        = count_q - CW'(1);
				p_rover        = fi_q;
			end else if (lf) begin
				// Merge into the left neighbor.
				p_wa_addr     = fi_q - IW'(1);
				p_wa_data     = left_q;
				p_wa_data.len = left_q.len + fe_q.len;
				p_shift       = (dn1_src < cnt_s);
				p_src         = dn1_src;
				p_moves       = (dn1_src < cnt_s) ? (cnt_s - dn1_src) : '0;
				p_count       = count_q - CW'(1);
				p_rover       = rov_dec;
			end else begin
				p_wa_data.used = 1'b0;
			end
		end else if (lf) begin
			// Partial free handed to the free left neighbor.
			p_act          = 1'b1;
			p_wa_addr      = fi_q - IW'(1);
			p_wa_data      = left_q;
			p_wa_data.len  = left_q.len + sz_a;
			p_wb           = 1'b1;
			p_wb_addr      = fi_q;
			p_wb_data.len  = fe_q.len - sz_a;
			p_wb_data.base = fe_q.base + sz_a;
		end else if (full) begin
			p_status = STS_TABLE_FULL;
		end else begin
			// Partial free split off as a new free segment in front.
			p_act          = 1'b1;
			p_shift        = 1'b1;
			p_up           = 1'b1;
			p_src          = cnt_s - SW'(1);
			p_moves        = cnt_s - fi_s;
			p_wa_data.used = 1'b0;
			p_wa_data.len  = sz_a;
			p_wb           = 1'b1;
			p_wb_data.used = 1'b1;
			p_wb_data.len  = fe_q.len - sz_a;
			p_wb_data.base = fe_q.base + sz_a;
			p_count        = count_q + CW'(1);
			p_rover        = rov_inc;
		end
	end

	// Memory read address selection.
	always_comb begin
		mem_ra = scan_addr_q;
		if (cmd.rd_left) begin
			mem_ra = fi_q - IW'(1);
		end else if (cmd.rd_right) begin
			mem_ra = fi_q + IW'(1);
		end else if (cmd.shift) begin
			mem_ra = sh_src_q[IW-1:0];
		end
	end

	// Memory write selection.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = pl_wa_addr_q;
		mem_wd = pl_wa_data_q;
		if (cmd.init) begin
			mem_we = 1'b1;
			mem_wa = '0;
			mem_wd = '{used: 1'b0, len: ADDR_BITS'(region_q), base: '0};
		end else if (cmd.shift) begin
			mem_we = sh_v_s1;
			mem_wa = sh_dst_s1;
			mem_wd = rdata_q;
		end else if (cmd.wr_a) begin
			mem_we = 1'b1;
		end else if (cmd.wr_b) begin
			mem_we = 1'b1;
			mem_wa = pl_wb_addr_q;
			mem_wd = pl_wb_data_q;
		end
	end

	// Segment table storage.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rdata_q <= mem_q[mem_ra];
	end

	// Control state: region, count, rover, scan and shift valid flags and counters, plan flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q   <= DEFAULT_REGION;
			count_q    <= CW'(1);
			rover_q    <= '0;
			scan_v_s1  <= 1'b0;
			scan_n_q   <= '0;
			sh_v_s1    <= 1'b0;
			sh_left_q  <= '0;
			pl_act_q   <= 1'b0;
			pl_shift_q <= 1'b0;
			pl_wb_q    <= 1'b0;
		end else begin
			if (cmd.cfg_wr) begin
				region_q <= cfg_data;
			end
			if (cmd.init) begin
				count_q <= CW'(1);
				rover_q <= '0;
			end
			// Scan start: allocate runs from the rover, free from entry zero.
			if (cmd.check) begin
				scan_n_q  <= '0;
				scan_v_s1 <= 1'b0;
				if (is_alloc && !size_zero && (CW'(rover_q) >= count_q)) begin
					rover_q <= '0;
				end
			end
			// One table read issued per cycle, wrapping at the fill count.
			if (cmd.scan) begin
				if (scan_n_q != count_q) begin
					scan_n_q  <= scan_n_q + CW'(1);
					scan_v_s1 <= 1'b1;
				end else begin
					scan_v_s1 <= 1'b0;
				end
			end
			if (cmd.plan) begin
				pl_act_q   <= p_act && (p_status == STS_OK);
				pl_shift_q <= p_shift && (p_status == STS_OK);
				pl_wb_q    <= p_wb;
				sh_left_q  <= (p_shift && (p_status == STS_OK)) ? p_moves : '0;
				if (p_act && (p_status == STS_OK)) begin
					count_q <= p_count;
					rover_q <= p_rover;
				end
			end
			// Shift engine: read one entry per cycle, write it in the following cycle.
			if (cmd.shift) begin
				if (sh_left_q != '0) begin
					sh_left_q <= sh_left_q - SW'(1);
					sh_v_s1   <= 1'b1;
				end else begin
					sh_v_s1 <= 1'b0;
				end
			end else begin
				sh_v_s1 <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_cmd_q    <= command;
			req_size_q   <= size;
			req_addr_q   <= address;
			res_status_q <= STS_OK;
			res_start_q  <= '0;
		end
		if (cmd.check) begin
			if (is_alloc) begin
				scan_addr_q <= (CW'(rover_q) >= count_q) ? '0 : rover_q;
			end else begin
				scan_addr_q <= '0;
			end
			if (is_alloc && size_zero) begin
				res_status_q <= STS_NO_SPACE;
			end
		end
		if (cmd.scan) begin
			scan_idx_s1 <= scan_addr_q;
			if (scan_addr_q == IW'(count_q - CW'(1))) begin
				scan_addr_q <= '0;
			end else begin
				scan_addr_q <= scan_addr_q + IW'(1);
			end
			if (scan_v_s1 && scan_match) begin
				fi_q <= scan_idx_s1;
				fe_q <= rdata_q;
			end else if (!scan_v_s1 && (scan_n_q == count_q)) begin
				res_status_q <= is_alloc ? STS_NO_SPACE : STS_BAD_ADDR;
			end
		end
		if (cmd.rd_right) begin
			left_q <= rdata_q;
		end
		if (cmd.nb_cap) begin
			right_q <= rdata_q;
		end
		if (cmd.plan) begin
			pl_wa_addr_q <= p_wa_addr;
			pl_wa_data_q <= p_wa_data;
			pl_wb_addr_q <= p_wb_addr;
			pl_wb_data_q <= p_wb_data;
			sh_up_q      <= p_up;
			sh_d2_q      <= p_d2;
			sh_src_q     <= p_src;
			res_status_q <= p_status;
			if (is_alloc && (p_status == STS_OK)) begin
				res_start_q <= FIELD_W'(fe_q.base);
			end
		end
		if (cmd.shift && (sh_left_q != '0)) begin
			if (sh_up_q) begin
				sh_dst_s1 <= IW'(sh_src_q + SW'(1));
				sh_src_q  <= sh_src_q - SW'(1);
			end else begin
				sh_dst_s1 <= IW'(sh_src_q - (sh_d2_q ? SW'(2) : SW'(1)));
				sh_src_q  <= sh_src_q + SW'(1);
			end
		end
	end

	// Status to the controller.
	always_comb begin
		stat.alloc_zero = is_alloc && size_zero;
		stat.scan_hit   = scan_v_s1 && scan_match;
		stat.scan_miss  = !scan_v_s1 && (scan_n_q == count_q);
		stat.act        = pl_act_q;
		stat.shift_any  = pl_shift_q;
		stat.shift_done = (sh_left_q == '0) && !sh_v_s1;
		stat.wb_en      = pl_wb_q;
	end

	assign status    = res_status_q;
	assign start_res = res_start_q;

endmodule

FILE: hdl/resource_map_next_fit_allocator.sv
// Top level of the next-fit resource map allocator.
// Depends on rmnf_pkg, rmnf_ctrl and rmnf_dpath.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------
//  config    | cfg_valid / cfg_ready     | cfg_data (region_size)
//  request   | start, taken when !busy   | command, size, address
//  result    | done, one-cycle strobe    | status, start_res
//
// A request lasts longer for each table entry scanned and each entry moved; the
// segment table memory has one read and one write port, one access each per cycle.
// After reset and after each region_size write the table is rebuilt while busy is
// high. Results cannot be stalled; done is high one cycle.
module resource_map_next_fit_allocator
	import rmnf_pkg::*;
#(
	parameter int MAX_SEGMENTS = 64,
	parameter int ADDR_BITS    = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [FIELD_W-1:0]  cfg_data,
	input  logic                start,
	output logic                busy,
	input  logic                command,
	input  logic [FIELD_W-1:0]  size,
	input  logic [FIELD_W-1:0]  address,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [FIELD_W-1:0]  start_res
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer.
	rmnf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_valid (cfg_valid),
		.stat      (stat),
		.busy      (busy),
		.done      (done),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	// Table and arithmetic.
	rmnf_dpath #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.ADDR_BITS    (ADDR_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_data  (cfg_data),
		.command   (command),
		.size      (size),
		.address   (address),
		.status    (status),
		.start_res (start_res)
	);

endmodule

FILE: hdl/rmnf_chk.sv
// Port-level checker of the next-fit resource map allocator, bound to the top level.
// Depends on rmnf_pkg and resource_map_next_fit_allocator_assert.svh.
`include "resource_map_next_fit_allocator_assert.svh"

module rmnf_chk
	import rmnf_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [STATUS_W-1:0] status,
	input logic [FIELD_W-1:0]  start_res
);

	// A result strobe lasts exactly one cycle.
	`RMNF_ASSERT_NEXT(a_done_pulse, done, !done)

	// A result appears only while a request is in flight.
	`RMNF_ASSERT_NOW(a_done_busy, done, busy)

	// Status codes stay within the defined set.
	`RMNF_ASSERT_NOW(a_status_range, done, status <= STS_TABLE_FULL)

	// A failed request reports a zero start offset.
	`RMNF_ASSERT_NOW(a_fail_zero, done && (status != STS_OK), start_res == '0)

	// An accepted request makes the block busy in the next cycle.
	`RMNF_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

endmodule

bind resource_map_next_fit_allocator rmnf_chk u_chk (.*);

FILE: sim/testbench.sv
// Self-checking testbench of the next-fit resource map allocator.
// Depends on rmnf_pkg and resource_map_next_fit_allocator; predicts each result from its own
// copy of the segment table and compares it with the block's output.
module testbench;
	import rmnf_pkg::*;

	localparam int NSEG = 64;
	localparam int QUIET_LIMIT = 20000;

	// One queued request or region_size write; free addresses and sizes may be
	// resolved from the predicted table when the request is driven.
	typedef struct {
		bit          is_cfg;
		logic [15:0] region;
		logic        cmd;
		logic [15:0] size;
		logic [15:0] addr;
		int          addr_mode;  // 0 as given, 1 base of a used segment
		int          size_mode;  // 0 as given, 1 whole segment, 2 part of it, 3 one too many
	} req_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [15:0]         start_res;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;
	logic start = 1'b0;
	logic busy;
	logic command = CMD_ALLOC;
	logic [15:0] size = '0;
	logic [15:0] address = '0;
	logic done;
	logic [STATUS_W-1:0] status;
	logic [15:0] start_res;

	req_t pending[$];
	result_t expected_results[$];
	req_t issued;
	int gap = 0;
	int settle = 0;
	int errors = 0;
	int n_requests = 0;
	int n_writes = 0;
	int n_ok = 0;
	int quiet = 0;

	// Predicted segment table.
	logic [15:0] seg_base[NSEG];
	logic [15:0] seg_len[NSEG];
	bit          seg_used[NSEG];
	int          seg_cnt;
	int          next_pos;

	resource_map_next_fit_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.start(start), .busy(busy), .command(command), .size(size), .address(address),
		.done(done), .status(status), .start_res(start_res)
	);

	always #1 clk = ~clk;

	// Rebuild the table as one free segment covering the region.
	function automatic void map_reset(logic [15:0] region);
		for (int j = 0; j < NSEG; j++) begin
			seg_base[j] = '0;
			seg_len[j] = '0;
			seg_used[j] = 1'b0;
		end
		seg_len[0] = region;
		seg_cnt = 1;
		next_pos = 0;
	endfunction

	function automatic void open_gap(int k);
		for (int j = seg_cnt; j > k; j--) begin
			seg_base[j] = seg_base[j-1];
			seg_len[j] = seg_len[j-1];
			seg_used[j] = seg_used[j-1];
		end
		seg_cnt++;
		if (next_pos >= k)
			next_pos++;
	endfunction

	function automatic void drop_entry(int k);
		for (int j = k; j + 1 < seg_cnt; j++) begin
			seg_base[j] = seg_base[j+1];
			seg_len[j] = seg_len[j+1];
			seg_used[j] = seg_used[j+1];
		end
		seg_cnt--;
		seg_base[seg_cnt] = '0;
		seg_len[seg_cnt] = '0;
		seg_used[seg_cnt] = 1'b0;
		if (next_pos >= k)
			next_pos--;
	endfunction

	// Next-fit allocation from the rover.
	function automatic logic [STATUS_W-1:0] allocate(logic [15:0] units, output logic [15:0] at);
		int f;
		int i;
		f = -1;
		at = '0;
		if (units == 0)
			return STS_NO_SPACE;
		if (next_pos >= seg_cnt)
			next_pos = 0;
		for (int n = 0; n < seg_cnt; n++) begin
			i = (next_pos + n) % seg_cnt;
			if (!seg_used[i] && seg_len[i] >= units) begin
				f = i;
				break;
			end
		end
		if (f < 0)
			return STS_NO_SPACE;
		if (seg_len[f] == units) begin
			seg_used[f] = 1'b1;
			next_pos = f;
		end else begin
			if (seg_cnt >= NSEG)
				return STS_TABLE_FULL;
			open_gap(f);
			seg_used[f] = 1'b1;
			seg_len[f] = units;
			seg_used[f+1] = 1'b0;
			seg_base[f+1] = seg_base[f] + units;
			seg_len[f+1] = seg_len[f+1] - units;
			next_pos = f + 1;
		end
		at = seg_base[f];
		return STS_OK;
	endfunction

	// Release of a used segment, whole or its leading part.
	function automatic logic [STATUS_W-1:0] release_units(logic [15:0] units, logic [15:0] at);
		int i;
		i = -1;
		for (int j = 0; j < seg_cnt; j++)
			if (seg_used[j] && seg_base[j] == at) begin
				i = j;
				break;
			end
		if (i < 0)
			return STS_BAD_ADDR;
		if (units > seg_len[i])
			return STS_TOO_BIG;
		if (units == 0)
			return STS_OK;
		if (units == seg_len[i]) begin
			seg_used[i] = 1'b0;
			if (i + 1 < seg_cnt && !seg_used[i+1]) begin
				seg_len[i] = seg_len[i] + seg_len[i+1];
				drop_entry(i + 1);
				next_pos = i;
				if (i > 0 && !seg_used[i-1]) begin
					seg_len[i-1] = seg_len[i-1] + seg_len[i];
					drop_entry(i);
					next_pos = i - 1;
				end
			end else if (i > 0 && !seg_used[i-1]) begin
				seg_len[i-1] = seg_len[i-1] + seg_len[i];
				drop_entry(i);
			end
			return STS_OK;
		end
		if (i > 0 && !seg_used[i-1]) begin
			seg_len[i-1] = seg_len[i-1] + units;
			seg_base[i] = seg_base[i] + units;
			seg_len[i] = seg_len[i] - units;
			return STS_OK;
		end
		if (seg_cnt >= NSEG)
			return STS_TABLE_FULL;
		open_gap(i);
		seg_used[i] = 1'b0;
		seg_len[i] = units;
		seg_base[i+1] = seg_base[i] + units;
		seg_len[i+1] = seg_len[i+1] - units;
		return STS_OK;
	endfunction

	// Fill in a free request from the predicted table at the time it is driven.
	function automatic req_t resolve(req_t r);
		int owners[$];
		int k;
		logic [15:0] l;
		if (r.addr_mode != 1)
			return r;
		for (int j = 0; j < seg_cnt; j++)
			if (seg_used[j])
				owners.push_back(j);
		if (owners.size() == 0)
			return r;
		k = owners[$urandom_range(0, owners.size() - 1)];
		l = seg_len[k];
		r.addr = seg_base[k];
		case (r.size_mode)
			1: r.size = l;
			2: r.size = (l > 1) ? 16'($urandom_range(1, l - 1)) : l;
			3: r.size = l + 16'd1;
			default: ;
		endcase
		return r;
	endfunction

	function automatic void add_request(logic c, logic [15:0] s, logic [15:0] a);
		req_t r;
		r = '{0, '0, c, s, a, 0, 0};
		pending.push_back(r);
	endfunction

	// Region write followed by random traffic; smax bounds most allocation sizes.
	function automatic void add_phase(logic [15:0] region, int n, int smax);
		req_t r;
		int p;
		r = '{1, region, CMD_ALLOC, '0, '0, 0, 0};
		pending.push_back(r);
		for (int k = 0; k < n; k++) begin
			r = '{0, '0, CMD_ALLOC, '0, 16'($urandom), 0, 0};
			p = $urandom_range(0, 99);
			if (p < 55) begin
				p = $urandom_range(0, 99);
				if (p < 4)
					r.size = '0;
				else if (p < 9)
					r.size = 16'($urandom);
				else if (p < 11)
					r.size = 16'hFFFF;
				else
					r.size = 16'($urandom_range(1, smax));
			end else begin
				r.cmd = CMD_FREE;
				r.size = 16'($urandom);
				p = $urandom_range(0, 99);
				if (p >= 10) begin
					r.addr_mode = 1;
					if (p < 55)
						r.size_mode = 1;
					else if (p < 82)
						r.size_mode = 2;
					else if (p < 92)
						r.size_mode = 3;
					else if (p < 96)
						r.size = '0;
				end
			end
			pending.push_back(r);
		end
	endfunction

	// Request and region write driver.
	always @(posedge clk or negedge arst_n) begin : driver
		req_t r;
		result_t e;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
		end else if (start && !busy) begin
			if (issued.cmd == CMD_ALLOC)
				e.status = allocate(issued.size, e.start_res);
			else begin
				e.status = release_units(issued.size, issued.addr);
				e.start_res = '0;
			end
			if (e.status == STS_OK)
				n_ok++;
			expected_results.push_back(e);
			n_requests++;
			start <= 1'b0;
			gap <= $urandom_range(0, 4);
		end else if (cfg_valid && cfg_ready) begin
			map_reset(cfg_data);
			n_writes++;
			cfg_valid <= 1'b0;
			gap <= $urandom_range(0, 4);
		end else if (!start && !cfg_valid) begin
			if (gap > 0)
				gap <= gap - 1;
			else if (pending.size() > 0) begin
				if (pending[0].is_cfg) begin
					// Region writes wait until the block has gone quiet.
					if (expected_results.size() == 0 && !busy) begin
						if (settle >= 4) begin
							r = pending.pop_front();
							cfg_data <= r.region;
							cfg_valid <= 1'b1;
							settle <= 0;
						end else
							settle <= settle + 1;
					end else
						settle <= 0;
				end else begin
					r = resolve(pending.pop_front());
					issued = r;
					command <= r.cmd;
					size <= r.size;
					address <= r.addr;
					start <= 1'b1;
				end
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin : monitor
		result_t e;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected: status %0d start_res %0d",
					$time, status, start_res);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (status !== e.status) begin
					$display("%0t: status expected %0d, got %0d", $time, e.status, status);
					errors++;
				end
				if (start_res !== e.start_res) begin
					$display("%0t: start_res expected %0d, got %0d",
						$time, e.start_res, start_res);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if ((start && !busy) || (cfg_valid && cfg_ready) || done)
			quiet <= 0;
		else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		map_reset(DEFAULT_REGION);
		// Directed requests on the reset region.
		add_request(CMD_ALLOC, 16'd0, 16'd0);
		add_request(CMD_ALLOC, 16'd100, 16'hFFFF);
		add_request(CMD_ALLOC, 16'd900, 16'd0);
		add_request(CMD_ALLOC, 16'd1, 16'd0);
		add_request(CMD_FREE, 16'd5, 16'd5);
		add_request(CMD_FREE, 16'd101, 16'd0);
		add_request(CMD_FREE, 16'd0, 16'd0);
		add_request(CMD_FREE, 16'd40, 16'd0);
		add_request(CMD_FREE, 16'd60, 16'd40);
		add_request(CMD_FREE, 16'd900, 16'd100);
		add_request(CMD_ALLOC, 16'hFFFF, 16'd0);
		add_request(CMD_ALLOC, 16'd1000, 16'd0);
		add_request(CMD_FREE, 16'd1000, 16'd0);
		add_request(CMD_ALLOC, 16'd1, 16'd0);
		add_request(CMD_ALLOC, 16'd2, 16'd0);
		add_request(CMD_ALLOC, 16'd3, 16'd0);
		add_request(CMD_FREE, 16'd2, 16'd1);
		add_request(CMD_FREE, 16'd1, 16'd3);
		add_request(CMD_FREE, 16'd1, 16'd0);
		add_request(CMD_FREE, 16'd2, 16'd4);
		add_request(CMD_FREE, 16'hFFFF, 16'hFFFF);
		// Random phases across region sizes, extremes included.
		add_phase(16'd0, 60, 4);
		add_phase(16'd1, 60, 2);
		add_phase(16'hFFFF, 180, 8000);
		add_phase(16'd200, 250, 3);
		add_phase(16'd5, 80, 3);
		add_phase(16'd1000, 250, 60);
		add_phase(16'hFFFF, 150, 65535);
		add_phase(16'($urandom_range(1, 65535)), 200, 500);
		add_phase(16'd300, 250, 4);
		add_phase(16'd64, 170, 2);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Drain, then allow a final latency window for stray results.
		while (pending.size() > 0 || start || cfg_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		$display("Ran %0d requests (%0d succeeded) over %0d region writes.",
			n_requests, n_ok, n_writes);
		if (errors == 0 && expected_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
